@@ rtl/core/planar_pose_integrator_unit_defines.svh @@
// Assertion helpers shared by the planar pose integrator RTL.
`ifndef PLANAR_POSE_INTEGRATOR_UNIT_DEFINES_SVH
`define PLANAR_POSE_INTEGRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ppi_pkg.sv @@
package ppi_pkg;

  localparam int unsigned DATA_W    = 16;  // speed, turn rate, heading, step
  localparam int unsigned POS_W     = 32;  // Q16.16 position
  localparam int unsigned XY_W      = 27;  // CORDIC vector, Q8.16 plus growth
  localparam int unsigned Z_W       = 33;  // CORDIC angle, 2^31 = pi
  localparam int unsigned TAB_IDX_W = 5;   // arctangent table index
  localparam int unsigned MUL_W     = 32;  // shared multiplier operand
  localparam int unsigned PROD_W    = 64;  // shared multiplier product

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic [DATA_W-1:0] STEP_SCALE_RST = 16'd3277;

  localparam logic signed [MUL_W-1:0] INV_PI_Q32      = 32'sd1367130551;
  localparam logic signed [MUL_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  typedef struct packed {
    logic load;  // take a new vector and angle
    logic iter;  // run one micro-rotation
  } ppi_cordic_ctl_t;

  // atan(2^-i) in binary-angle units, 2^31 = pi
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [TAB_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = 33'sd536870912;
      5'd1:    v = 33'sd316933406;
      5'd2:    v = 33'sd167458907;
      5'd3:    v = 33'sd85004756;
      5'd4:    v = 33'sd42667331;
      5'd5:    v = 33'sd21354465;
      5'd6:    v = 33'sd10679838;
      5'd7:    v = 33'sd5340245;
      5'd8:    v = 33'sd2670163;
      5'd9:    v = 33'sd1335087;
      5'd10:   v = 33'sd667544;
      5'd11:   v = 33'sd333772;
      5'd12:   v = 33'sd166886;
      5'd13:   v = 33'sd83443;
      5'd14:   v = 33'sd41722;
      5'd15:   v = 33'sd20861;
      5'd16:   v = 33'sd10430;
      5'd17:   v = 33'sd5215;
      5'd18:   v = 33'sd2608;
      5'd19:   v = 33'sd1304;
      5'd20:   v = 33'sd652;
      5'd21:   v = 33'sd326;
      5'd22:   v = 33'sd163;
      5'd23:   v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/ppi_mul.sv @@
module ppi_mul (
  input  logic                                clk_i,
  input  logic signed [ppi_pkg::MUL_W-1:0]    a_i,
  input  logic signed [ppi_pkg::MUL_W-1:0]    b_i,
  output logic signed [ppi_pkg::PROD_W-1:0]   p_o
);
  import ppi_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // product is registered; one result per cycle
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ rtl/core/ppi_cordic.sv @@
module ppi_cordic (
  input  logic                                 clk_i,
  input  ppi_pkg::ppi_cordic_ctl_t             ctl_i,
  input  logic        [ppi_pkg::TAB_IDX_W-1:0] idx_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]    forward_speed_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]    side_speed_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]    heading_i,
  output logic signed [ppi_pkg::XY_W-1:0]      x_o,
  output logic signed [ppi_pkg::XY_W-1:0]      y_o
);
  import ppi_pkg::*;

  localparam int unsigned FRAC_W = 8;  // Q8.8 -> Q8.16
  localparam int unsigned EXT_W  = XY_W - DATA_W - FRAC_W;
  localparam logic signed [DATA_W-1:0] QUARTER = 16'sd16384;
  localparam logic signed [Z_W-1:0]    HALF    = 33'sd2147483648;

  logic signed [XY_W-1:0] x_q, y_q, x_d, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic signed [XY_W-1:0] x0, y0, xs, ys;
  logic signed [Z_W-1:0]  z0;
  logic                   wrap_pos, wrap_neg;

  assign x0 = {{EXT_W{forward_speed_i[DATA_W-1]}}, forward_speed_i, {FRAC_W{1'b0}}};
  assign y0 = {{EXT_W{side_speed_i[DATA_W-1]}}, side_speed_i, {FRAC_W{1'b0}}};
  assign z0 = {heading_i[DATA_W-1], heading_i, {DATA_W{1'b0}}};

  // beyond +-pi/2: flip the vector and move the angle by pi
  assign wrap_pos = heading_i > QUARTER;
  assign wrap_neg = heading_i < -QUARTER;

  assign xs = x_q >>> idx_i;
  assign ys = y_q >>> idx_i;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctl_i.load) begin
      if (wrap_pos) begin
        x_d = -x0;
        y_d = -y0;
        z_d = z0 - HALF;
      end else if (wrap_neg) begin
        x_d = -x0;
        y_d = -y0;
        z_d = z0 + HALF;
      end else begin
        x_d = x0;
        y_d = y0;
        z_d = z0;
      end
    end else if (ctl_i.iter) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_lut(idx_i);
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_lut(idx_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

@@ rtl/core/planar_pose_integrator_unit.sv @@
// Planar pose integrator: 2-D dead reckoning from body-frame velocity commands.
// Input channel (in_valid_i / in_ready_o) carries forward_speed, side_speed and
// turn_rate; one transaction is one command. Output channel (out_valid_o /
// out_ready_i) carries the updated pose_x, pose_y and pose_heading, one
// transaction per command. Config channel (cfg_valid_i / cfg_ready_o) writes
// step_scale; it is always ready and should only be used while the block is idle.
// Each command runs the CORDIC micro-rotations, one per cycle, plus six passes
// through the single shared 32x32 multiplier.
// in_ready_o is high only while the sequencer idles. A finished pose sits in the
// output register; the next command is taken meanwhile and runs until its
// result must be stored, where it waits while the receiver stalls.
// Reset clears the pose to zero, step_scale to 3277 (about 0.05 s) and drops
// out_valid_o.
`include "planar_pose_integrator_unit_defines.svh"

module planar_pose_integrator_unit #(
  parameter int unsigned CORDIC_STEPS = ppi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [ppi_pkg::DATA_W-1:0]  forward_speed_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]  side_speed_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]  turn_rate_i,
  // pose channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ppi_pkg::POS_W-1:0]   pose_x_o,
  output logic signed [ppi_pkg::POS_W-1:0]   pose_y_o,
  output logic signed [ppi_pkg::DATA_W-1:0]  pose_heading_o,
  // config channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic        [ppi_pkg::DATA_W-1:0]  step_scale_i
);
  import ppi_pkg::*;

  localparam int unsigned CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
  localparam int unsigned RXY_W = 25;  // gain-corrected vector, Q8.16

  // Rounding offsets (half LSB) for each product shift
  localparam logic signed [PROD_W-1:0] RND_HEAD = 64'sd1 <<< 44;
  localparam logic signed [PROD_W-1:0] RND_GAIN = 64'sd1 <<< 29;
  localparam logic signed [PROD_W-1:0] RND_STEP = 64'sd1 <<< 15;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_HMUL1 = 11'b000_0000_0010,  // step * turn_rate
    S_HMUL2 = 11'b000_0000_0100,  // * 2^32/pi
    S_HEAD  = 11'b000_0000_1000,  // heading update, CORDIC load
    S_CITER = 11'b000_0001_0000,  // micro-rotations
    S_GX    = 11'b000_0010_0000,  // x * gain
    S_GY    = 11'b000_0100_0000,  // y * gain
    S_SX    = 11'b000_1000_0000,  // x * step
    S_SY    = 11'b001_0000_0000,  // y * step, pos_x update
    S_UPD   = 11'b010_0000_0000,  // pos_y update
    S_OUT   = 11'b100_0000_0000   // store result
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [DATA_W-1:0]        step_q;
  logic signed [DATA_W-1:0] heading_q, heading_d;
  logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
  logic signed [DATA_W-1:0] fwd_q, side_q, turn_q;
  logic signed [RXY_W-1:0]  rx_q, ry_q;
  logic signed [POS_W-1:0]  pose_x_q, pose_y_q;
  logic signed [DATA_W-1:0] pose_h_q;
  logic                     out_valid_q;

  logic                     in_fire, out_load;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] hd_sum, g_sum, s_sum;
  logic signed [RXY_W-1:0]  g_rnd;
  logic signed [POS_W:0]    s_rnd;
  logic signed [XY_W-1:0]   cx, cy;
  ppi_cordic_ctl_t          cordic_ctl;

  function automatic logic signed [POS_W-1:0] sat_add(
    input logic signed [POS_W-1:0] pos,
    input logic signed [POS_W:0]   dv
  );
    logic signed [POS_W+1:0] sum;
    logic signed [POS_W-1:0] res;
    sum = {{2{pos[POS_W-1]}}, pos} + {dv[POS_W], dv};
    if (sum[POS_W+1:POS_W-1] == 3'b000 || sum[POS_W+1:POS_W-1] == 3'b111) begin
      res = sum[POS_W-1:0];
    end else if (sum[POS_W+1]) begin
      res = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(POS_W-1){1'b1}}};
    end
    return res;
  endfunction

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  // ---------------------------------------------------------------------------
  // Shared multiplier and its operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = MUL_W'(turn_q);
    mul_b = $signed({{(MUL_W-DATA_W){1'b0}}, step_q});
    unique case (state_q)
      S_HMUL1: begin
        mul_a = MUL_W'(turn_q);
        mul_b = $signed({{(MUL_W-DATA_W){1'b0}}, step_q});
      end
      S_HMUL2: begin
        mul_a = $signed(prod[MUL_W-1:0]);
        mul_b = INV_PI_Q32;
      end
      S_GX: begin
        mul_a = MUL_W'(cx);
        mul_b = CORDIC_GAIN_Q30;
      end
      S_GY: begin
        mul_a = MUL_W'(cy);
        mul_b = CORDIC_GAIN_Q30;
      end
      S_SX: begin
        mul_a = MUL_W'(rx_q);
        mul_b = $signed({{(MUL_W-DATA_W){1'b0}}, step_q});
      end
      S_SY: begin
        mul_a = MUL_W'(ry_q);
        mul_b = $signed({{(MUL_W-DATA_W){1'b0}}, step_q});
      end
      default: ;
    endcase
  end

  ppi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // round-half-up of the product at each shift point
  assign hd_sum    = prod + RND_HEAD;
  assign g_sum     = prod + RND_GAIN;
  assign s_sum     = prod + RND_STEP;
  assign heading_d = heading_q + $signed(hd_sum[60:45]);  // binary angle wraps
  assign g_rnd     = $signed(g_sum[30+RXY_W-1:30]);
  assign s_rnd     = $signed(s_sum[16+POS_W:16]);

  // ---------------------------------------------------------------------------
  // CORDIC rotation unit
  // ---------------------------------------------------------------------------
  assign cordic_ctl = '{load: (state_q == S_HEAD), iter: (state_q == S_CITER)};

  ppi_cordic u_cordic (
    .clk_i           (clk_i),
    .ctl_i           (cordic_ctl),
    .idx_i           (TAB_IDX_W'(cnt_q)),
    .forward_speed_i (fwd_q),
    .side_speed_i    (side_q),
    .heading_i       (heading_d),
    .x_o             (cx),
    .y_o             (cy)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE:  if (in_fire) state_d = S_HMUL1;
      S_HMUL1: state_d = S_HMUL2;
      S_HMUL2: state_d = S_HEAD;
      S_HEAD: begin
        cnt_d   = '0;
        state_d = S_CITER;
      end
      S_CITER: begin
        if (cnt_q == LAST_STEP) begin
          cnt_d   = '0;
          state_d = S_GX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_GX:    state_d = S_GY;
      S_GY:    state_d = S_SX;
      S_SX:    state_d = S_SY;
      S_SY:    state_d = S_UPD;
      S_UPD:   state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      step_q      <= STEP_SCALE_RST;
      heading_q   <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        step_q <= step_scale_i;
      end
      if (state_q == S_HEAD) begin
        heading_q <= heading_d;
      end
      if (state_q == S_SY) begin
        pos_x_q <= sat_add(pos_x_q, s_rnd);
      end
      if (state_q == S_UPD) begin
        pos_y_q <= sat_add(pos_y_q, s_rnd);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fwd_q  <= forward_speed_i;
      side_q <= side_speed_i;
      turn_q <= turn_rate_i;
    end
    if (state_q == S_GY) begin
      rx_q <= g_rnd;
    end
    if (state_q == S_SX) begin
      ry_q <= g_rnd;
    end
    if (out_load) begin
      pose_x_q <= pos_x_q;
      pose_y_q <= pos_y_q;
      pose_h_q <= heading_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pose_x_o       = pose_x_q;
  assign pose_y_o       = pose_y_q;
  assign pose_heading_o = pose_h_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PPI_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_fire, !in_ready_o, "ready after accept")
  `PPI_ASSERT_IMP(a_cordic_full_run, clk_i, rst_ni, state_q == S_GX, $past(state_q) == S_CITER && $past(cnt_q) == LAST_STEP, "CORDIC run cut short")
  `PPI_ASSERT_NXT(a_hold_on_stall, clk_i, rst_ni, state_q == S_OUT && out_valid_q && !out_ready_i, state_q == S_OUT, "pending pose overwritten")
  `PPI_ASSERT_IMP(a_out_from_seq, clk_i, rst_ni, out_valid_q && !$past(out_valid_q), $past(state_q) == S_OUT, "pose valid without store")

endmodule

@@ bench/ppi_pose_checker.sv @@
`timescale 1ns / 100ps

module ppi_pose_checker #(
  parameter int unsigned CORDIC_STEPS = ppi_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]  forward_speed_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]  side_speed_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]  turn_rate_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic signed [ppi_pkg::POS_W-1:0]   pose_x_i,
  input  logic signed [ppi_pkg::POS_W-1:0]   pose_y_i,
  input  logic signed [ppi_pkg::DATA_W-1:0]  pose_heading_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic        [ppi_pkg::DATA_W-1:0]  step_scale_i,
  output int                                 fail_count_o,
  output int                                 pending_poses_o,
  output int                                 poses_checked_o,
  output int                                 saturated_poses_o
);
  import ppi_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [DATA_W-1:0] heading;
  } pose_t;

  localparam longint HALF_TURN    = 64'sd2147483648;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint POS_MAX      = 64'sd2147483647;
  localparam longint POS_MIN      = -64'sd2147483648;
  localparam int     LUT_LEN      = 24;

  // atan(2^-k), 2^31 = pi
  longint arctan_lut [0:LUT_LEN-1] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  pose_t             pose_now;
  logic [DATA_W-1:0] step_now;
  pose_t             expected_poses [$];
  int                fails, reported, checked, saturated;

  // round half up, then drop s fraction bits
  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic pose_t advance_pose(input pose_t cur, input logic [DATA_W-1:0] step,
                                         input logic signed [DATA_W-1:0] fwd,
                                         input logic signed [DATA_W-1:0] side,
                                         input logic signed [DATA_W-1:0] turn);
    longint dtheta, vx, vy, ang, nx, ny;
    logic [DATA_W-1:0] hd;
    pose_t nxt;
    int k;
    dtheta = round_shift(longint'(step) * longint'(turn) * longint'(INV_PI_Q32), 45);
    hd     = cur.heading + dtheta[DATA_W-1:0];
    vx     = longint'(fwd) * 256;
    vy     = longint'(side) * 256;
    ang    = longint'($signed(hd)) * 65536;
    // fold the back half-plane onto the front one
    if (ang > QUARTER_TURN) begin
      vx  = -vx;
      vy  = -vy;
      ang = ang - HALF_TURN;
    end else if (ang < -QUARTER_TURN) begin
      vx  = -vx;
      vy  = -vy;
      ang = ang + HALF_TURN;
    end
    for (k = 0; k < CORDIC_STEPS && k < LUT_LEN; k++) begin
      if (ang >= 0) begin
        nx  = vx - (vy >>> k);
        ny  = vy + (vx >>> k);
        ang = ang - arctan_lut[k];
      end else begin
        nx  = vx + (vy >>> k);
        ny  = vy - (vx >>> k);
        ang = ang + arctan_lut[k];
      end
      vx = nx;
      vy = ny;
    end
    vx = round_shift(vx * longint'(CORDIC_GAIN_Q30), 30);
    vy = round_shift(vy * longint'(CORDIC_GAIN_Q30), 30);
    nxt.x       = POS_W'(clamp_pos(longint'(cur.x) + round_shift(vx * longint'(step), 16)));
    nxt.y       = POS_W'(clamp_pos(longint'(cur.y) + round_shift(vy * longint'(step), 16)));
    nxt.heading = hd;
    return nxt;
  endfunction

  task automatic report_field(input string field, input longint want, input longint got);
    fails++;
    if (reported < 10) begin
      reported++;
      $display("%0t: %s wrong on pose %0d: expected %0d, got %0d",
               $realtime, field, checked, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pose_t want;
    if (!rst_ni) begin
      pose_now  = '0;
      step_now  = STEP_SCALE_RST;
      expected_poses.delete();
      fails     = 0;
      reported  = 0;
      checked   = 0;
      saturated = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_poses.size() == 0) begin
          fails++;
          if (reported < 10) begin
            reported++;
            $display("%0t: pose transaction with no command pending", $realtime);
          end
        end else begin
          want = expected_poses.pop_front();
          if (pose_x_i !== want.x)
            report_field("pose_x", longint'(want.x), longint'(pose_x_i));
          if (pose_y_i !== want.y)
            report_field("pose_y", longint'(want.y), longint'(pose_y_i));
          if (pose_heading_i !== want.heading)
            report_field("pose_heading", longint'(want.heading), longint'(pose_heading_i));
          if (longint'(want.x) inside {POS_MAX, POS_MIN} ||
              longint'(want.y) inside {POS_MAX, POS_MIN})
            saturated++;
        end
        checked++;
      end
      if (cfg_valid_i && cfg_ready_i)
        step_now = step_scale_i;
      if (in_valid_i && in_ready_i) begin
        pose_now = advance_pose(pose_now, step_now, forward_speed_i, side_speed_i, turn_rate_i);
        expected_poses = {expected_poses, pose_now};
      end
    end
    fail_count_o      <= fails;
    pending_poses_o   <= expected_poses.size();
    poses_checked_o   <= checked;
    saturated_poses_o <= saturated;
  end

endmodule

@@ bench/planar_pose_integrator_unit_tb.sv @@
`timescale 1ns / 100ps

module planar_pose_integrator_unit_tb;
  import ppi_pkg::*;

  localparam int unsigned STEPS       = CORDIC_STEPS_DEF;
  localparam int unsigned LATENCY     = STEPS + 10;
  localparam int unsigned HOLD_CYCLES = 600;   // long receiver hold-off
  localparam int unsigned PHASE_ITEMS = 30;    // commands per general phase

  // At full step (65535) this rate turns the heading by exactly a quarter
  // turn: 65535 * 6434 / (pi * 2^13) = 16383.8, which rounds to 16384.
  localparam logic signed [DATA_W-1:0] TURN_QUARTER = 16'sd6434;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [DATA_W-1:0]  forward_speed_i;
  logic signed [DATA_W-1:0]  side_speed_i;
  logic signed [DATA_W-1:0]  turn_rate_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [POS_W-1:0]   pose_x_o;
  logic signed [POS_W-1:0]   pose_y_o;
  logic signed [DATA_W-1:0]  pose_heading_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic        [DATA_W-1:0]  step_scale_i;

  int fail_count, pending_poses, poses_checked, saturated_poses;
  int commands_sent, step_writes, burst_left, hold_requests;

  planar_pose_integrator_unit #(
    .CORDIC_STEPS (STEPS)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .forward_speed_i (forward_speed_i),
    .side_speed_i    (side_speed_i),
    .turn_rate_i     (turn_rate_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pose_x_o        (pose_x_o),
    .pose_y_o        (pose_y_o),
    .pose_heading_o  (pose_heading_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .step_scale_i    (step_scale_i)
  );

  // Checker sits beside the block: tracks the pose, predicts every result and
  // compares it against each pose transaction.
  ppi_pose_checker #(
    .CORDIC_STEPS (STEPS)
  ) pose_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .forward_speed_i   (forward_speed_i),
    .side_speed_i      (side_speed_i),
    .turn_rate_i       (turn_rate_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .pose_x_i          (pose_x_o),
    .pose_y_i          (pose_y_o),
    .pose_heading_i    (pose_heading_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .step_scale_i      (step_scale_i),
    .fail_count_o      (fail_count),
    .pending_poses_o   (pending_poses),
    .poses_checked_o   (poses_checked),
    .saturated_poses_o (saturated_poses)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hang guard: well over the slowest legal run (~1100 commands, each at
  // worst a full CORDIC pass plus the longest sender gap and receiver stalls).
  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Pose receiver. Runs in phases of random length, each with its own stall
  // rate (some phases never stall). When the stimulus asks for a hold-off it
  // drops ready for HOLD_CYCLES, so the block backs up and stalls its input.
  initial begin : pose_sink
    int unsigned stall_pct, phase_left, holds_done;
    out_ready_i = 1'b0;
    stall_pct   = 0;
    phase_left  = 0;
    holds_done  = 0;
    forever begin
      @(posedge clk_i);
      if (holds_done < hold_requests) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      if (phase_left == 0) begin
        phase_left = $urandom_range(300, 40);
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 30;
          3:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      phase_left--;
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one command and wait for its transaction. Must be entered on a
  // clock edge. Commands go out in bursts; at the end of a burst valid drops
  // for a gap of random length so gaps land on every step of the block's pass.
  task automatic send_cmd(input logic [DATA_W-1:0] fwd, input logic [DATA_W-1:0] side,
                          input logic [DATA_W-1:0] turn);
    in_valid_i      <= 1'b1;
    forward_speed_i <= fwd;
    side_speed_i    <= side;
    turn_rate_i     <= turn;
    do @(posedge clk_i); while (!in_ready_o);
    commands_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(60, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 10) : $urandom_range(5);
    end
  endtask

  // Stop offering and wait until every predicted pose has come back.
  // The extra edge lets the checker count the last command first.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_poses != 0) @(posedge clk_i);
  endtask

  // step_scale write; only called with the block idle
  task automatic write_step(input logic [DATA_W-1:0] value);
    cfg_valid_i  <= 1'b1;
    step_scale_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i  <= 1'b0;
    step_writes++;
  endtask

  initial begin : stimulus
    int unsigned k, p;
    logic [DATA_W-1:0] next_step;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    forward_speed_i = '0;
    side_speed_i    = '0;
    turn_rate_i     = '0;
    cfg_valid_i     = 1'b0;
    step_scale_i    = '0;
    commands_sent   = 0;
    step_writes     = 0;
    burst_left      = 0;
    hold_requests   = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed, reset step (0.05 s), heading held at zero
    send_cmd(16'h0000, 16'h0000, 16'h0000);   // standing still
    send_cmd(16'h7fff, 16'h0000, 16'h0000);
    send_cmd(16'h8000, 16'h8000, 16'h0000);
    send_cmd(16'h0000, 16'h7fff, 16'h0000);
    send_cmd(16'h5555, 16'haaaa, 16'h0000);
    send_cmd(16'haaaa, 16'h5555, 16'h0000);
    drain();

    // --- directed, full step: quarter turns walk the heading through
    // +pi/2 (fold boundary), pi (stored as -pi), back to 0 and -pi/2
    write_step(16'hffff);
    send_cmd(16'h0100, 16'h0000, TURN_QUARTER);
    send_cmd(16'h0100, 16'h0100, TURN_QUARTER);
    send_cmd(16'h0000, 16'h0000, 16'h0000);   // no motion while at pi
    send_cmd(16'h7fff, 16'h7fff, -TURN_QUARTER);
    send_cmd(16'h8000, 16'h7fff, -TURN_QUARTER);
    send_cmd(16'h7fff, 16'h8000, -TURN_QUARTER);
    drain();

    // --- directed, zero step: extreme inputs must leave the pose alone
    write_step(16'h0000);
    send_cmd(16'h7fff, 16'h8000, 16'h7fff);
    send_cmd(16'h8000, 16'h7fff, 16'h8000);
    send_cmd(16'hffff, 16'h0001, 16'h0001);
    send_cmd(16'h0001, 16'hffff, 16'hffff);
    drain();

    // --- sprints at full step with heading fixed at -pi/2 and no turning:
    // the first drives x to the positive limit and y to the negative one,
    // the second runs back across both axes into the opposite limits.
    // The receiver holds off early on while commands keep coming.
    write_step(16'hffff);
    hold_requests++;
    burst_left = 80;
    for (k = 0; k < 290; k++)
      send_cmd(16'($urandom_range(32767, 30000)), 16'($urandom_range(32767, 30000)),
               16'h0000);
    for (k = 0; k < 560; k++)
      send_cmd(-16'($urandom_range(32768, 30000)), -16'($urandom_range(32768, 30000)),
               16'h0000);
    drain();

    // --- general random phases over several step settings, ending on the
    // reset value; one more hold-off on the full-step phase
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       next_step = 16'($urandom);
        1:       next_step = 16'h0001;
        2:       next_step = 16'hffff;
        3:       next_step = 16'h8000;
        4:       next_step = 16'($urandom);
        default: next_step = STEP_SCALE_RST;
      endcase
      write_step(next_step);
      if (p == 2) begin
        hold_requests++;
        burst_left = 60;
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(9))
          0:       send_cmd(16'h0000, 16'h0000, 16'($urandom));
          1:       send_cmd(16'(int'($urandom_range(512)) - 256),
                            16'(int'($urandom_range(512)) - 256),
                            16'(int'($urandom_range(512)) - 256));
          default: send_cmd(16'($urandom), 16'($urandom), 16'($urandom));
        endcase
      end
      drain();
    end

    // quiet tail: anything the block emits now is unexpected
    repeat (2 * LATENCY) @(posedge clk_i);

    $display("Run sent %0d velocity commands across %0d step_scale writes and checked %0d poses,",
             commands_sent, step_writes, poses_checked);
    $display("%0d of them with a position axis pinned at a limit.", saturated_poses);
    if (fail_count == 0 && pending_poses == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
